>>> src/mm64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared constants and types of the 64-bit murmur hash engine.
// ----------------------------------------------------------------------------
package mm64_pkg;

   // hash constants
   localparam logic [63:0] MUL_CONST  = 64'hc6a4_a793_5bd1_e995;
   localparam int unsigned SHIFT_R    = 47;
   localparam logic [63:0] SEED_RESET = 64'd11111111;

   // field widths
   localparam int unsigned LEN_W  = 31;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned CNT_W  = 4;

   // how a word enters the hash
   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_TAIL  = 2'd1,
      KIND_FULL  = 2'd2
   } kind_type;

   // classified word, front to back
   typedef struct packed {
      logic              first;
      logic              last;
      logic              mismatch;
      kind_type          kind;
      logic [LEN_W-1:0]  length;
      logic [WORD_W-1:0] word;
   } entry_type;

   // queue status toward the front
   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

endpackage

>>> src/mm64_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm64_mul
// Low 64 bits of operand times the hash multiplier, from three 32x32 partial
// products; the low product and the summed cross terms are registered.
// ----------------------------------------------------------------------------
module mm64_mul (
   input  logic        clock,
   input  logic [63:0] op,
   output logic [63:0] prod
);
   import mm64_pkg::*;

   logic [63:0] low_ff;
   logic [63:0] low_in;
   logic [31:0] cross_ff;
   logic [31:0] cross_in;
   logic [63:0] hi_lo;
   logic [63:0] lo_hi;

   // partial products, cross terms only need their low halves
   always_comb begin
      low_in   = {32'd0, op[31:0]} * {32'd0, MUL_CONST[31:0]};
      hi_lo    = {32'd0, op[63:32]} * {32'd0, MUL_CONST[31:0]};
      lo_hi    = {32'd0, op[31:0]} * {32'd0, MUL_CONST[63:32]};
      cross_in = hi_lo[31:0] + lo_hi[31:0];
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      cross_ff <= cross_in;
   end

   // final sum
   assign prod = low_ff + {cross_ff, 32'd0};

endmodule

>>> src/mm64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm64_front
// Accepts words, tracks message boundaries and byte count, classifies each
// word and pushes it into the queue.
// ----------------------------------------------------------------------------
module mm64_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mm64_pkg::LEN_W-1:0]   req_message_length,
   input  logic [mm64_pkg::WORD_W-1:0]  req_data_word,
   input  logic [mm64_pkg::CNT_W-1:0]   req_byte_count,
   input  logic                         req_last,
   input  mm64_pkg::queue_status_type   queue_status,
   output logic                         push,
   output mm64_pkg::entry_type          push_entry
);
   import mm64_pkg::*;

   logic             in_msg_ff;
   logic             in_msg_in;
   logic [LEN_W-1:0] seen_ff;
   logic [LEN_W-1:0] seen_in;
   logic [LEN_W-1:0] decl_ff;
   logic [LEN_W-1:0] decl_in;
   logic [3:0]       cnt;
   logic [LEN_W-1:0] seen_base;
   logic [LEN_W-1:0] decl_cur;
   logic [63:0]      tail_mask;

   assign req_ready = ~queue_status.full;
   assign push      = req_valid & req_ready;

   // classify the word
   always_comb begin
      cnt       = req_byte_count[3] ? 4'd8 : req_byte_count;
      seen_base = in_msg_ff ? seen_ff : '0;
      decl_cur  = in_msg_ff ? decl_ff : req_message_length;
      tail_mask = ~({64{1'b1}} << {req_byte_count[2:0], 3'b000});

      push_entry.first    = ~in_msg_ff;
      push_entry.last     = req_last;
      push_entry.length   = req_message_length;
      seen_in             = seen_base + {{(LEN_W-4){1'b0}}, cnt};
      push_entry.mismatch = (seen_in != decl_cur);
      if (cnt == 4'd8) begin
         push_entry.kind = KIND_FULL;
         push_entry.word = req_data_word;
      end else if (cnt == 4'd0) begin
         push_entry.kind = KIND_EMPTY;
         push_entry.word = req_data_word;
      end else begin
         push_entry.kind = KIND_TAIL;
         push_entry.word = req_data_word & tail_mask;
      end
      in_msg_in = ~req_last;
      decl_in   = decl_cur;
   end

   // message tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         seen_ff   <= '0;
         decl_ff   <= '0;
      end else if (push) begin
         in_msg_ff <= in_msg_in;
         seen_ff   <= seen_in;
         decl_ff   <= decl_in;
      end
   end

endmodule

>>> src/mm64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm64_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module mm64_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mm64_pkg::entry_type        push_entry,
   input  logic                       pop,
   output mm64_pkg::entry_type        head,
   output mm64_pkg::queue_status_type status
);
   import mm64_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head              = mem_ff[rd_ptr_ff];
   assign status.full       = (count_ff == 2'd2);
   assign status.head_valid = (count_ff != 2'd0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/mm64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm64_back
// Sequencer that runs seeding, word mixing, tail folding and finalization
// through one shared multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module mm64_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [63:0]                 seed,
   input  mm64_pkg::entry_type         head,
   input  mm64_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [63:0]                 rsp_hash_value,
   output logic                        rsp_length_mismatch
);
   import mm64_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_CAP  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      STEP_SEED = 3'd0,
      STEP_K1   = 3'd1,
      STEP_K2   = 3'd2,
      STEP_H    = 3'd3,
      STEP_FIN  = 3'd4
   } step_type;

   state_type   state_ff;
   state_type   state_in;
   step_type    step_ff;
   step_type    step_in;
   logic [63:0] op_ff;
   logic [63:0] op_in;
   logic [63:0] h_ff;
   logic [63:0] h_in;
   logic        mis_ff;
   logic        mis_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] rsp_hash_ff;
   logic [63:0] rsp_hash_in;
   logic        rsp_mis_ff;
   logic        rsp_mis_in;
   logic [63:0] prod;
   logic [63:0] hc;
   logic        dispatch;

   function automatic logic [63:0] xorshift(input logic [63:0] x);
      return x ^ (x >> SHIFT_R);
   endfunction

   mm64_mul u_mul (
      .clock (clock),
      .op    (op_ff),
      .prod  (prod)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hash_value      = rsp_hash_ff;
   assign rsp_length_mismatch = rsp_mis_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      h_in         = h_ff;
      mis_in       = mis_ff;
      pop          = 1'b0;
      dispatch     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_mis_in   = rsp_mis_ff;
      hc = (state_ff == ST_CAP && step_ff == STEP_SEED) ? (seed ^ prod) : h_ff;

      case (state_ff)
         ST_IDLE: begin
            if (queue_status.head_valid) begin
               if (head.first) begin
                  op_in    = {{(64-LEN_W){1'b0}}, head.length};
                  step_in  = STEP_SEED;
                  state_in = ST_MUL;
               end else begin
                  dispatch = 1'b1;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_CAP;
         end
         ST_CAP: begin
            case (step_ff)
               STEP_SEED: begin
                  dispatch = 1'b1;
               end
               STEP_K1: begin
                  op_in    = xorshift(prod);
                  step_in  = STEP_K2;
                  state_in = ST_MUL;
               end
               STEP_K2: begin
                  op_in    = h_ff ^ prod;
                  step_in  = STEP_H;
                  state_in = ST_MUL;
               end
               STEP_H: begin
                  h_in   = prod;
                  pop    = 1'b1;
                  mis_in = head.mismatch;
                  if (head.last) begin
                     op_in    = xorshift(prod);
                     step_in  = STEP_FIN;
                     state_in = ST_MUL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               STEP_FIN: begin
                  h_in     = xorshift(prod);
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = h_ff;
               rsp_mis_in   = mis_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // start the body of a word once the hash is seeded
      if (dispatch) begin
         h_in = hc;
         case (head.kind)
            KIND_FULL: begin
               op_in    = head.word;
               step_in  = STEP_K1;
               state_in = ST_MUL;
            end
            KIND_TAIL: begin
               op_in    = hc ^ head.word;
               step_in  = STEP_H;
               state_in = ST_MUL;
            end
            default: begin
               pop    = 1'b1;
               mis_in = head.mismatch;
               if (head.last) begin
                  op_in    = xorshift(hc);
                  step_in  = STEP_FIN;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      op_ff       <= op_in;
      h_ff        <= h_in;
      mis_ff      <= mis_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_mis_ff  <= rsp_mis_in;
   end

endmodule

>>> src/murmur64a_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur64a_hash
// 64-bit MurmurHash64A over messages of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per handshake; the first word of a message
//   carries the declared byte length, req_last marks the final word.
//   rsp_ channel: one word per message with the hash and a flag that is
//   set when the counted bytes differ from the declared length.
//   csr_ port: csr_wr_en writes the seed; write only while idle.
// Sequencing (one shared multiplier, each multiply through states MUL and CAP):
//   a full 8-byte word runs steps K1, K2 and H, a tail word step H, an empty
//   word no multiply; the first word of a message adds the seeding step, the
//   last adds the finalization step plus the load of the result register.
//   A word reaches the back end through the queue's storage; a two-word queue
//   lets the front keep accepting while the back end works.
// Reset clears the queue, message tracking and the result valid flag, and
// loads the seed with 11111111. A stalled receiver holds the result; the
// back end then waits at its next result and the queue fills up.
// ----------------------------------------------------------------------------
module murmur64a_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mm64_pkg::LEN_W-1:0]   req_message_length,
   input  logic [mm64_pkg::WORD_W-1:0]  req_data_word,
   input  logic [mm64_pkg::CNT_W-1:0]   req_byte_count,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [63:0]                  rsp_hash_value,
   output logic                         rsp_length_mismatch,
   input  logic                         csr_wr_en,
   input  logic [63:0]                  csr_wr_data
);
   import mm64_pkg::*;

   logic [63:0]      hash_seed_ff;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type queue_status;

   // seed register
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         hash_seed_ff <= csr_wr_data;
      end
   end

   mm64_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_message_length (req_message_length),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last           (req_last),
      .queue_status       (queue_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   mm64_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   mm64_back u_back (
      .clock               (clock),
      .reset               (reset),
      .seed                (hash_seed_ff),
      .head                (head),
      .queue_status        (queue_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hash_value      (rsp_hash_value),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

endmodule
